### rtl/maf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 16;

   localparam int ADDR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W     = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W     = SAMPLE_WIDTH + ADDR_W;
   localparam int CFG_W     = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] RESET_WINDOW = CFG_W'(8);

   // Word index of the window length register.
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [LEN_W-1:0]               len;
      logic                           resum;
   } maf_item_type;

   // A length of zero averages the new sample alone; lengths above MAX_WINDOW saturate.
   function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] wl);
      logic [LEN_W-1:0] r;
      if (wl == '0) begin
         r = LEN_W'(1);
      end else if (int'(wl) > MAX_WINDOW) begin
         r = LEN_W'(MAX_WINDOW);
      end else begin
         r = LEN_W'(int'(wl));
      end
      return r;
   endfunction

   function automatic logic signed [SUM_W-1:0] sext_sum(
      input logic signed [SAMPLE_WIDTH-1:0] x);
      return {{(SUM_W - SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
   endfunction

endpackage

`default_nettype wire

### rtl/maf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module maf_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   input  wire logic signed [maf_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                                  req_full,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [maf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [maf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [maf_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready,
   output logic                                  q_push,
   output maf_pkg::maf_item_type                 q_item,
   input  wire logic                             q_full
);
   import maf_pkg::*;

   logic [CFG_W-1:0]      wl_ff;
   logic [CFG_W-1:0]      wl_in;
   logic [LEN_W-1:0]      last_len_ff;
   logic [LEN_W-1:0]      last_len_in;
   logic [LEN_W-1:0]      cur_len;
   logic                  csr_write;
   logic [CSR_ADDR_W-3:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wl_in = wl_ff;
      if (csr_write && csr_index == REG_WINDOW_LENGTH) begin
         wl_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_WINDOW_LENGTH) begin
         csr_prdata = {{(CSR_DATA_W - CFG_W){1'b0}}, wl_ff};
      end
   end

   assign cur_len  = eff_len(wl_ff);
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   // The back keeps a running sum only for the length it was built with, so
   // an item that arrives under a new length asks for a fresh sum.
   assign q_item.sample = req_sample;
   assign q_item.len    = cur_len;
   assign q_item.resum  = (cur_len != last_len_ff);

   assign last_len_in = q_push ? cur_len : last_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff       <= RESET_WINDOW;
         last_len_ff <= eff_len(RESET_WINDOW);
      end else begin
         wl_ff       <= wl_in;
         last_len_ff <= last_len_in;
      end
   end

endmodule

`default_nettype wire

### rtl/maf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module maf_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire maf_pkg::maf_item_type push_item,
   output logic                       full,
   input  wire logic                  pop,
   output maf_pkg::maf_item_type      pop_item,
   output logic                       empty
);
   import maf_pkg::*;

   maf_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/maf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module maf_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [maf_pkg::SUM_W-1:0]    dividend,
   input  wire logic [maf_pkg::LEN_W-1:0]           divisor,
   output logic                                     done,
   output logic signed [maf_pkg::SAMPLE_WIDTH-1:0]  quotient
);
   import maf_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               neg_ff;
   logic [SUM_W-1:0]   quo_ff;
   logic [SUM_W-1:0]   quo_in;
   logic [LEN_W-1:0]   rem_ff;
   logic [LEN_W-1:0]   rem_in;
   logic [LEN_W-1:0]   div_ff;
   logic [LEN_W:0]     rem_sh;
   logic [LEN_W:0]     rem_diff;
   logic               fits;
   logic [SUM_W-1:0]   quo_signed;

   // Restoring division on the magnitude, one quotient bit per cycle.
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
      rem_diff = rem_sh - {1'b0, div_ff};
      fits     = (rem_sh >= {1'b0, div_ff});
      quo_in   = {quo_ff[SUM_W-2:0], fits};
      rem_in   = fits ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
   end

   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = quo_signed[SAMPLE_WIDTH-1:0];
   assign done       = done_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         quo_ff <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

`default_nettype wire

### rtl/maf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module maf_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire maf_pkg::maf_item_type               q_item,
   input  wire logic                                q_empty,
   output logic                                     q_pop,
   input  wire logic                                rsp_pop,
   output logic                                     rsp_empty,
   output logic signed [maf_pkg::SAMPLE_WIDTH-1:0]  rsp_average
);
   import maf_pkg::*;

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_LREAD  = 3'd1;
   localparam logic [2:0] B_LUPD   = 3'd2;
   localparam logic [2:0] B_SWRITE = 3'd3;
   localparam logic [2:0] B_SWEEP  = 3'd4;
   localparam logic [2:0] B_DIVST  = 3'd5;
   localparam logic [2:0] B_DIVW   = 3'd6;
   localparam logic [2:0] B_OUT    = 3'd7;

   logic [2:0]                     state_ff;
   logic [2:0]                     state_in;
   logic signed [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];
   logic                           valid_ff [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic                           rd_vld_ff;
   logic                           rd_en;
   logic [ADDR_W-1:0]              rd_addr;
   logic                           wr_en;

   logic [ADDR_W-1:0]              wp_ff;
   logic [ADDR_W-1:0]              wp_in;
   logic [ADDR_W-1:0]              rp_ff;
   logic [ADDR_W-1:0]              rp_in;
   logic signed [SUM_W-1:0]        sum_ff;
   logic signed [SUM_W-1:0]        sum_in;
   logic signed [SUM_W-1:0]        acc_ff;
   logic signed [SUM_W-1:0]        acc_in;
   logic [LEN_W-1:0]               issue_ff;
   logic [LEN_W-1:0]               issue_in;
   logic [LEN_W-1:0]               recv_ff;
   logic [LEN_W-1:0]               recv_in;
   logic                           pend_ff;
   logic                           pend_in;
   maf_item_type                   cur_ff;
   logic signed [SAMPLE_WIDTH-1:0] avg_ff;
   logic                           out_vld_ff;
   logic                           out_vld_in;
   logic signed [SAMPLE_WIDTH-1:0] out_avg_ff;

   logic signed [SAMPLE_WIDTH-1:0] old_sample;
   logic                           div_start;
   logic                           div_done;
   logic signed [SAMPLE_WIDTH-1:0] div_quot;
   logic                           out_load;
   logic                           out_free;

   function automatic logic [ADDR_W-1:0] addr_next(input logic [ADDR_W-1:0] a);
      return (a == ADDR_W'(MAX_WINDOW - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_prev(input logic [ADDR_W-1:0] a);
      return (a == '0) ? ADDR_W'(MAX_WINDOW - 1) : a - 1'b1;
   endfunction

   // Slot of the sample that drops out of the window when the next one is
   // written at a; for a full-depth window that is slot a itself.
   function automatic logic [ADDR_W-1:0] leave_addr(input logic [ADDR_W-1:0] a,
                                                     input logic [LEN_W-1:0] n);
      int d;
      d = int'(a) - int'(n);
      if (d < 0) begin
         d = d + MAX_WINDOW;
      end
      return ADDR_W'(d);
   endfunction

   assign old_sample = rd_vld_ff ? rd_data_ff : '0;
   assign out_free   = !out_vld_ff || rsp_pop;
   assign rsp_empty  = !out_vld_ff;
   assign rsp_average = out_avg_ff;

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = rp_ff;
      wr_en     = 1'b0;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      sum_in    = sum_ff;
      acc_in    = acc_ff;
      issue_in  = issue_ff;
      recv_in   = recv_ff;
      pend_in   = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = q_item.resum ? B_SWRITE : B_LREAD;
            end
         end
         B_LREAD: begin
            rd_en    = 1'b1;
            rd_addr  = leave_addr(wp_ff, cur_ff.len);
            state_in = B_LUPD;
         end
         B_LUPD: begin
            wr_en    = 1'b1;
            wp_in    = addr_next(wp_ff);
            sum_in   = sum_ff + sext_sum(cur_ff.sample) - sext_sum(old_sample);
            state_in = B_DIVST;
         end
         B_SWRITE: begin
            wr_en    = 1'b1;
            wp_in    = addr_next(wp_ff);
            rp_in    = wp_ff;
            acc_in   = '0;
            issue_in = '0;
            recv_in  = '0;
            state_in = B_SWEEP;
         end
         B_SWEEP: begin
            // Reads go out newest first; each returns in the cycle after it issues.
            if (issue_ff != cur_ff.len) begin
               rd_en    = 1'b1;
               rd_addr  = rp_ff;
               rp_in    = addr_prev(rp_ff);
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               acc_in  = acc_ff + sext_sum(old_sample);
               recv_in = recv_ff + 1'b1;
               if (recv_ff + 1'b1 == cur_ff.len) begin
                  sum_in   = acc_ff + sext_sum(old_sample);
                  state_in = B_DIVST;
               end
            end
         end
         B_DIVST: begin
            div_start = 1'b1;
            state_in  = B_DIVW;
         end
         B_DIVW: begin
            if (div_done) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= cur_ff.sample;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   // Slots never written read as zero, as after a cleared history.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wp_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (div_done) begin
         avg_ff <= div_quot;
      end
      if (out_load) begin
         out_avg_ff <= avg_ff;
      end
      rp_ff    <= rp_in;
      acc_ff   <= acc_in;
      issue_ff <= issue_in;
      recv_ff  <= recv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         wp_ff      <= '0;
         sum_ff     <= '0;
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         sum_ff     <= sum_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
      end
   end

   maf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cur_ff.len),
      .done     (div_done),
      .quotient (div_quot)
   );

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && out_vld_ff && !rsp_pop) |=>
         (state_ff == B_OUT && $stable(out_avg_ff)))
      else $error("waiting result overwritten");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == B_DIVW)
      else $error("divider finished with nobody waiting");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_SWEEP |-> (issue_ff <= cur_ff.len && recv_ff < cur_ff.len))
      else $error("history sweep ran past the window");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !wr_en)
      else $error("two history writes for one beat");

endmodule

`default_nettype wire

### rtl/moving_average_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Boxcar moving-average filter over signed fixed-point samples.
// Input queue: drive req_sample and raise req_push; the beat is taken on a
// clock edge where req_full is low. Output queue: while rsp_empty is low the
// mean of the latest window sits on rsp_average; raise rsp_pop to take it.
// window_length lives at byte address 0 of the csr_ port (APB style, always
// ready) and keeps 7 bits; zero averages the new sample alone, above 64 saturates.
// Each sample passes from queue to result through a read of the sample that
// leaves the window, the running-sum update, and a one-bit-a-step divider.
// The first sample after a change of the effective window length instead
// rebuilds the sum from the history memory, one read port slot per sample of
// the new window. A two-entry queue lets the next samples in while the
// back works, and a one-beat result register holds the answer while the
// receiver stalls; the back waits in place until that register frees.
// Synchronous reset empties both queues, restores a window of 8 and makes the
// whole history read as zero at once; no clearing pass is needed.
module moving_average_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   input  wire logic signed [maf_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                                     req_full,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic signed [maf_pkg::SAMPLE_WIDTH-1:0]  rsp_average,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [maf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [maf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [maf_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);
   import maf_pkg::*;

   logic         f_push;
   maf_item_type f_item;
   logic         q_full;
   logic         q_pop;
   maf_item_type q_item;
   logic         q_empty;

   maf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_sample  (req_sample),
      .req_full    (req_full),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .q_push      (f_push),
      .q_item      (f_item),
      .q_full      (q_full)
   );

   maf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   maf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_item      (q_item),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_average (rsp_average)
   );

endmodule

`default_nettype wire

### sim/maf_checker.sv
`timescale 1ns / 1ps

// Watches both queues and the register port of the filter. It keeps its own
// copy of the sample history and the window length, predicts one average per
// accepted sample beat, and compares each popped beat with the oldest prediction.
module maf_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   input  logic                                    req_full,
   input  logic signed [maf_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   input  logic signed [maf_pkg::SAMPLE_WIDTH-1:0] rsp_average,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [maf_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [maf_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   input  logic [maf_pkg::CSR_DATA_W-1:0]          csr_prdata,
   input  logic                                    csr_pready,
   output int                                      mismatches,
   output int                                      outstanding,
   output int                                      averages_checked
);
   import maf_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] history_copy [MAX_WINDOW];
   logic [ADDR_W-1:0]              next_slot;
   logic [CFG_W-1:0]               window_copy;
   logic signed [SAMPLE_WIDTH-1:0] pending_means [$];
   int                             fail_tally;
   int                             checked_tally;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_tally++;
   endtask

   always @(posedge clock) begin : watch
      int                             span;
      longint                         window_sum;
      logic [ADDR_W-1:0]              slot;
      logic signed [SAMPLE_WIDTH-1:0] mean;
      logic signed [SAMPLE_WIDTH-1:0] oldest;
      if (reset) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            history_copy[i] = '0;
         end
         next_slot = '0;
         window_copy = RESET_WINDOW;
         pending_means.delete();
         fail_tally = 0;
         checked_tally = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_LENGTH) begin
            if (csr_pwrite) begin
               window_copy = csr_pwdata[CFG_W-1:0];
            end else if (csr_prdata != CSR_DATA_W'(window_copy)) begin
               report_mismatch($sformatf("window length read %0d, holds %0d",
                                         csr_prdata, window_copy));
            end
         end

         if (!rsp_empty && rsp_pop) begin
            if (pending_means.size() == 0) begin
               report_mismatch($sformatf("average %0d popped with none due",
                                         rsp_average));
            end else begin
               oldest = pending_means.pop_front();
               checked_tally++;
               if (rsp_average !== oldest) begin
                  report_mismatch($sformatf("average %0d, predicted %0d",
                                            rsp_average, oldest));
               end
            end
         end

         if (req_push && !req_full) begin
            history_copy[next_slot] = req_sample;
            next_slot = next_slot + 1'b1;
            // Zero means the new sample alone; anything past the depth saturates.
            if (window_copy == '0) begin
               span = 1;
            end else if (int'(window_copy) > MAX_WINDOW) begin
               span = MAX_WINDOW;
            end else begin
               span = int'(window_copy);
            end
            window_sum = 0;
            for (int k = 1; k <= span; k++) begin
               slot = next_slot - ADDR_W'(k);
               window_sum += history_copy[slot];
            end
            // Signed integer division in SystemVerilog truncates toward zero.
            mean = SAMPLE_WIDTH'(window_sum / span);
            pending_means.push_back(mean);
         end
      end
      mismatches <= fail_tally;
      outstanding <= pending_means.size();
      averages_checked <= checked_tally;
   end

endmodule

### sim/tb_moving_average_filter.sv
`timescale 1ns / 1ps

module tb_moving_average_filter;
   import maf_pkg::*;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] req_sample = '0;
   logic                           req_full;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_average;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]          csr_paddr = '0;
   logic [CSR_DATA_W-1:0]          csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]          csr_prdata;
   logic                           csr_pready;

   int mismatches;
   int outstanding;
   int averages_checked;

   // Percent of cycles on which each side holds back.
   int send_idle = 35;
   int recv_idle = 85;
   int samples_sent = 0;
   int windows_set = 0;

   moving_average_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_sample  (req_sample),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_average (rsp_average),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   maf_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample       (req_sample),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_average      (rsp_average),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .averages_checked (averages_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Offers one sample beat after a random gap; push stays high across
   // back-to-back beats.
   task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
      int gap;
      gap = 0;
      while (gap < 24 && $urandom_range(0, 99) < send_idle) begin
         gap++;
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_full);
      samples_sent++;
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {REG_WINDOW_LENGTH, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Every sample yields an average, so once none is outstanding the block
   // is idle and the window length may change.
   task automatic set_window(input logic [CSR_DATA_W-1:0] data);
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_access(1'b1, data);
      csr_access(1'b0, '0);
      windows_set++;
   endtask

   initial begin : stimulus
      int fixed_windows [10];
      logic [CSR_DATA_W-1:0] wl;
      logic signed [SAMPLE_WIDTH-1:0] value;
      fixed_windows = '{1, 64, 0, 127, 2, 63, 65, 'h85, 3, 33};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset window of 8: fill with the positive extreme while the reset zeros are
      // still leaving, then flush with the negative extreme.
      repeat (9) push_sample(16'sh7FFF);
      repeat (9) push_sample(-16'sh8000);
      csr_access(1'b0, '0);
      // Truncation toward zero: the mean of -1 and 0 is 0.
      set_window(2);
      push_sample(-16'sd1);
      push_sample(16'sd0);
      set_window(1);
      push_sample(-16'sd1);
      push_sample(16'sh7FFF);
      set_window(0);
      push_sample(16'sd5);
      push_sample(-16'sh8000);
      set_window(127);
      push_sample(16'sh7FFF);
      push_sample(-16'sd1);

      for (int seg = 0; seg < 16; seg++) begin
         if (seg == 6) begin
            send_idle = 85;
            recv_idle = 35;
         end else if (seg == 12) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (seg < 10) begin
            wl = fixed_windows[seg];
         end else if (seg == 15) begin
            wl = $urandom_range(0, 255);
         end else begin
            wl = $urandom_range(1, 64);
         end
         set_window(wl);
         repeat (100) begin
            case ($urandom_range(0, 7))
               0: value = 16'sh7FFF;
               1: value = -16'sh8000;
               2: value = $signed(16'($urandom_range(0, 8))) - 16'sd4;
               default: value = SAMPLE_WIDTH'($urandom);
            endcase
            push_sample(value);
         end
      end

      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d samples over %0d window length settings;", samples_sent,
               windows_set);
      $display("%0d averages compared, %0d mismatches.", averages_checked, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #8000000;
      $display("Timeout with %0d averages still due", outstanding);
      $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/maf_pkg.sv
rtl/maf_front.sv
rtl/maf_queue.sv
rtl/maf_div.sv
rtl/maf_back.sv
rtl/moving_average_filter.sv
sim/maf_checker.sv
sim/tb_moving_average_filter.sv
